// ===== rtl/rth_pkg.sv =====
// Shared types, constants and the divider step for the RGB to HSV converter.
// Used by the channel interfaces and the top level; depends on nothing.
package rth_pkg;

    localparam int CH_W      = 8;
    localparam int HUE_W     = 15;
    localparam int DIV_STEPS = 13;
    localparam int DIV_W     = 9;
    localparam int NUM_W     = DIV_STEPS + DIV_W;
    localparam int STAGES    = DIV_STEPS + 3;

    localparam logic [HUE_W-1:0] HUE_TURN  = 15'd23040;
    localparam logic [HUE_W-1:0] OFF_RED   = 15'd19200;
    localparam logic [HUE_W-1:0] OFF_GREEN = 15'd3840;
    localparam logic [HUE_W-1:0] OFF_BLUE  = 15'd11520;
    localparam logic [NUM_W-1:0] HUE_SCALE = 22'd7680;
    localparam logic [NUM_W-1:0] SAT_SCALE = 22'd510;

    typedef struct packed {
        logic [DIV_W-1:0]     rem;
        logic [DIV_STEPS-1:0] word;
        logic [DIV_W-1:0]     dvs;
    } t_div;

    typedef struct packed {
        logic [CH_W-1:0]  val;
        logic [CH_W-1:0]  dif;
        logic [DIV_W-1:0] u;
        logic [HUE_W-1:0] off;
    } t_front;

    typedef struct packed {
        t_div             hue;
        t_div             sat;
        logic [HUE_W-1:0] off;
        logic             hue_zero;
        logic             sat_zero;
        logic [CH_W-1:0]  val;
    } t_dstage;

    // The dividend must be below dvs * 2**DIV_STEPS so the top bits start as a remainder.
    function automatic t_div div_init(logic [NUM_W-1:0] num, logic [DIV_W-1:0] dvs);
        t_div x;
        x.rem  = num[NUM_W-1:DIV_STEPS];
        x.word = num[DIV_STEPS-1:0];
        x.dvs  = dvs;
        return x;
    endfunction

    // One restoring step: the dividend bit shifts out of word and the quotient bit shifts in.
    function automatic t_div div_step(t_div x);
        logic [DIV_W:0] t;
        logic [DIV_W:0] diff;
        t_div           y;
        t    = {x.rem, x.word[DIV_STEPS-1]};
        diff = t - {1'b0, x.dvs};
        y    = x;
        if (t >= {1'b0, x.dvs}) begin
            y.rem  = diff[DIV_W-1:0];
            y.word = {x.word[DIV_STEPS-2:0], 1'b1};
        end else begin
            y.rem  = t[DIV_W-1:0];
            y.word = {x.word[DIV_STEPS-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

// ===== rtl/rth_pix_if.sv =====
// Input channel of the converter: one RGB pixel per beat with valid and ready.
// Depends on rth_pkg for the channel width.
interface rth_pix_if;
    import rth_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

// ===== rtl/rth_hsv_if.sv =====
// Output channel of the converter: one HSV result per beat with valid and ready.
// Depends on rth_pkg for the field widths.
interface rth_hsv_if;
    import rth_pkg::*;

    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue_out;
    logic [CH_W-1:0]  sat_out;
    logic [CH_W-1:0]  val_out;

    modport source (output valid, hue_out, sat_out, val_out, input ready);
    modport sink   (input valid, hue_out, sat_out, val_out, output ready);
endinterface

// ===== rtl/rgb_to_hsv_converter.sv =====
// Channel   | Dir | Payload                      | Handshake
// i_pix     | in  | red_in, green_in, blue_in    | valid / ready
// o_hsv     | out | hue_out, sat_out, val_out    | valid / ready
//
// One pixel is accepted per cycle unless a stall has backed the pipeline up to the input.
// Sixteen register stages carry it: max and min, divider setup, 13 divider steps, output.
// Every stage holds its own valid bit, so bubbles close up while the output stalls.
// Reset clears the valid bits only. A stall holds every occupied stage with no free stage after it.
// Depends on rth_pkg, rth_pix_if and rth_hsv_if.
module rgb_to_hsv_converter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rth_pix_if.sink   i_pix,
    rth_hsv_if.source o_hsv
);
    import rth_pkg::*;

    logic [STAGES-1:0] r_vld;
    logic [STAGES:0]   stg_rdy;
    logic [STAGES-1:0] stg_vin;

    t_front  r_front;
    t_front  n_front;
    t_dstage r_div [DIV_STEPS+1];
    t_dstage n_div [DIV_STEPS+1];

    logic [HUE_W-1:0] r_hue;
    logic [CH_W-1:0]  r_sat;
    logic [CH_W-1:0]  r_val;
    logic [HUE_W-1:0] n_hue;
    logic [CH_W-1:0]  n_sat;

    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   mn;
    logic              red_max;
    logic              green_max;
    logic signed [9:0] num;
    logic signed [9:0] u_full;
    logic [NUM_W-1:0]  hue_num;
    logic [NUM_W-1:0]  sat_num;
    logic [HUE_W-1:0]  hue_sum;

    always_comb begin
        mx = i_pix.red_in;
        if (i_pix.green_in > mx) mx = i_pix.green_in;
        if (i_pix.blue_in > mx)  mx = i_pix.blue_in;
        mn = i_pix.red_in;
        if (i_pix.green_in < mn) mn = i_pix.green_in;
        if (i_pix.blue_in < mn)  mn = i_pix.blue_in;
        red_max   = (mx == i_pix.red_in);
        green_max = !red_max && (mx == i_pix.green_in);
        priority if (red_max) begin
            num         = $signed({2'b00, i_pix.green_in}) - $signed({2'b00, i_pix.blue_in});
            n_front.off = OFF_RED;
        end else if (green_max) begin
            num         = $signed({2'b00, i_pix.blue_in}) - $signed({2'b00, i_pix.red_in});
            n_front.off = OFF_GREEN;
        end else begin
            num         = $signed({2'b00, i_pix.red_in}) - $signed({2'b00, i_pix.green_in});
            n_front.off = OFF_BLUE;
        end
        n_front.val = mx;
        n_front.dif = mx - mn;
        u_full      = num + $signed({2'b00, n_front.dif});
        n_front.u   = u_full[DIV_W-1:0];
    end

    always_comb begin
        hue_num = {13'b0, r_front.u} * HUE_SCALE + {14'b0, r_front.dif};
        sat_num = {14'b0, r_front.dif} * SAT_SCALE + {14'b0, r_front.val};
        n_div[0].hue      = div_init(hue_num, {r_front.dif, 1'b0});
        n_div[0].sat      = div_init(sat_num, {r_front.val, 1'b0});
        n_div[0].off      = r_front.off;
        n_div[0].hue_zero = (r_front.dif == '0);
        n_div[0].sat_zero = (r_front.val == '0);
        n_div[0].val      = r_front.val;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_div[k]     = r_div[k-1];
            n_div[k].hue = div_step(r_div[k-1].hue);
            n_div[k].sat = div_step(r_div[k-1].sat);
        end
    end

    always_comb begin
        hue_sum = {2'b00, r_div[DIV_STEPS].hue.word} + r_div[DIV_STEPS].off;
        if (r_div[DIV_STEPS].hue_zero) begin
            n_hue = '0;
        end else if (hue_sum >= HUE_TURN) begin
            n_hue = hue_sum - HUE_TURN;
        end else begin
            n_hue = hue_sum;
        end
        n_sat = r_div[DIV_STEPS].sat_zero ? '0 : r_div[DIV_STEPS].sat.word[CH_W-1:0];
    end

    always_comb begin
        stg_rdy[STAGES] = o_hsv.ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
        stg_vin = {r_vld[STAGES-2:0], i_pix.valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (stg_rdy[k]) r_vld[k] <= stg_vin[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0] && stg_vin[0]) r_front <= n_front;
        for (int k = 0; k <= DIV_STEPS; k++) begin
            if (stg_rdy[k+1] && stg_vin[k+1]) r_div[k] <= n_div[k];
        end
        if (stg_rdy[STAGES-1] && stg_vin[STAGES-1]) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= r_div[DIV_STEPS].val;
        end
    end

    assign i_pix.ready   = stg_rdy[0];
    assign o_hsv.valid   = r_vld[STAGES-1];
    assign o_hsv.hue_out = r_hue;
    assign o_hsv.sat_out = r_sat;
    assign o_hsv.val_out = r_val;

endmodule

// ===== rtl/rth_checker.sv =====
// Port-level checks for the RGB to HSV converter, and the bind that attaches them.
// Depends on rth_pkg and the top level rgb_to_hsv_converter.
module rth_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [rth_pkg::HUE_W-1:0] i_hue,
    input logic [rth_pkg::CH_W-1:0]  i_sat,
    input logic [rth_pkg::CH_W-1:0]  i_val
);
    import rth_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Output beat dropped while stalled.");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_hue < HUE_TURN))
        else $error("Hue is outside one full turn.");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_sat == '0) |-> (i_hue == '0))
        else $error("Grey pixel has a nonzero hue.");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_val == '0) |-> (i_sat == '0))
        else $error("Black pixel has a nonzero saturation.");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("Input stalled while the output side is ready.");

endmodule

bind rgb_to_hsv_converter rth_checker u_rth_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_hsv.valid),
    .i_out_ready (o_hsv.ready),
    .i_hue       (o_hsv.hue_out),
    .i_sat       (o_hsv.sat_out),
    .i_val       (o_hsv.val_out)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_hsv_converter: a scoreboard predicts each HSV beat.
// Depends on rth_pkg, rth_pix_if, rth_hsv_if and the converter top level.
module tb;
    import rth_pkg::*;

    localparam int HUE_SIXTH  = 3840;
    localparam int RANDOM_PIX = 1000;
    localparam int QUIET_FROM = 850;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYC  = 40;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
    } t_hsv;

    class hsv_scoreboard;
        t_hsv expected_hsv[$];
        int   mismatches = 0;

        function automatic t_hsv convert(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                         logic [CH_W-1:0] b);
            int   ri, gi, bi, mx, mn, d, num, base, n, hue, sat;
            t_hsv res;
            ri = r;
            gi = g;
            bi = b;
            mx = ri;
            mn = ri;
            hue = 0;
            sat = 0;
            if (gi > mx) mx = gi;
            if (bi > mx) mx = bi;
            if (gi < mn) mn = gi;
            if (bi < mn) mn = bi;
            d = mx - mn;
            if (mx > 0) sat = (510 * d + mx) / (2 * mx);
            if (d > 0) begin
                if (mx == ri) begin
                    num  = gi - bi;
                    base = 0;
                end else if (mx == gi) begin
                    num  = bi - ri;
                    base = 2 * HUE_SIXTH;
                end else begin
                    num  = ri - gi;
                    base = 4 * HUE_SIXTH;
                end
                n = HUE_SIXTH * num + base * d;
                if (n < 0) n += int'(HUE_TURN) * d;
                hue = (2 * n + d) / (2 * d);
                if (hue >= int'(HUE_TURN)) hue -= int'(HUE_TURN);
            end
            res.hue = hue[HUE_W-1:0];
            res.sat = sat[CH_W-1:0];
            res.val = mx[CH_W-1:0];
            return res;
        endfunction

        function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
            expected_hsv.push_back(convert(r, g, b));
        endfunction

        function void check_hsv(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                                logic [CH_W-1:0] val);
            t_hsv exp_hsv;
            if (expected_hsv.size() == 0) begin
                $display("%0t: unexpected beat hue=%0d sat=%0d val=%0d", $time, hue, sat, val);
                mismatches++;
                return;
            end
            exp_hsv = expected_hsv.pop_front();
            if (hue !== exp_hsv.hue) begin
                $display("%0t: hue expected %0d actual %0d", $time, exp_hsv.hue, hue);
                mismatches++;
            end
            if (sat !== exp_hsv.sat) begin
                $display("%0t: sat expected %0d actual %0d", $time, exp_hsv.sat, sat);
                mismatches++;
            end
            if (val !== exp_hsv.val) begin
                $display("%0t: val expected %0d actual %0d", $time, exp_hsv.val, val);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_hsv.size();
        endfunction
    endclass

    localparam logic [23:0] DIRECTED [0:21] = '{
        24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
        24'h00ffff, 24'hff00ff, 24'h808080, 24'h010101, 24'h010000, 24'h000001,
        24'hc8c864, 24'h64c8c8, 24'hc864c8, 24'hff0001, 24'hff0100, 24'hfffefe,
        24'h7f0080, 24'h01fe00, 24'hfe01ff, 24'h55aa00
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    rth_pix_if pix ();
    rth_hsv_if hsv ();

    rgb_to_hsv_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_hsv   (hsv)
    );

    hsv_scoreboard hsv_sb = new;
    int            pix_beats   = 0;
    int            idle_cycles = 0;
    bit            quiet       = 1'b0;

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && pix.valid && pix.ready) begin
            hsv_sb.note_pixel(pix.red_in, pix.green_in, pix.blue_in);
            pix_beats++;
        end
        if (i_rst_n && hsv.valid && hsv.ready)
            hsv_sb.check_hsv(hsv.hue_out, hsv.sat_out, hsv.val_out);
        if (i_rst_n && ((pix.valid && pix.ready) || (hsv.valid && hsv.ready)))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("[rgb_to_hsv_converter] ERROR");
        $finish;
    end

    initial begin
        hsv.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (quiet || $urandom_range(0, 2) != 0) begin
                hsv.ready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end else begin
                hsv.ready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
        end
    end

    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        int target;
        target = pix_beats + 1;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            pix.valid    = 1'b0;
            pix.red_in   = CH_W'($urandom);
            pix.green_in = CH_W'($urandom);
            pix.blue_in  = CH_W'($urandom);
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        pix.valid    = 1'b1;
        pix.red_in   = r;
        pix.green_in = g;
        pix.blue_in  = b;
        do @(negedge i_clk); while (pix_beats < target);
    endtask

    initial begin
        logic [CH_W-1:0] r, g, b, base;
        i_rst_n      = 1'b0;
        pix.valid    = 1'b0;
        pix.red_in   = '0;
        pix.green_in = '0;
        pix.blue_in  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[k])
            send_pixel(DIRECTED[k][23:16], DIRECTED[k][15:8], DIRECTED[k][7:0]);

        for (int k = 0; k < RANDOM_PIX; k++) begin
            if (k == QUIET_FROM) quiet = 1'b1;
            r = CH_W'($urandom);
            g = CH_W'($urandom);
            b = CH_W'($urandom);
            case ($urandom_range(0, 9))
                0: g = r;
                1: b = g;
                2: b = r;
                3: begin
                    base = CH_W'($urandom_range(2, 253));
                    r = base + CH_W'($urandom_range(0, 2)) - CH_W'(1);
                    g = base + CH_W'($urandom_range(0, 2)) - CH_W'(1);
                    b = base + CH_W'($urandom_range(0, 2)) - CH_W'(1);
                end
                4: begin
                    r = CH_W'($urandom_range(0, 3));
                    g = CH_W'($urandom_range(0, 3));
                    b = CH_W'($urandom_range(0, 3));
                end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
        pix.valid = 1'b0;

        while (hsv_sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
        if (hsv_sb.mismatches == 0)
            $display("[rgb_to_hsv_converter] OK");
        else
            $display("[rgb_to_hsv_converter] ERROR");
        $finish;
    end
endmodule
